// File: hdl/lsdf_pkg.sv
// Shared types, constants and compare functions for the line segment filter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lsdf_pkg;

   localparam int MAX_SEGMENTS = 256;
   localparam int COORD_BITS   = 16;
   localparam int ADDR_BITS    = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = ADDR_BITS + 1;
   localparam int TOL_BITS     = 16;
   localparam int TOTAL_BITS   = 9;
   localparam int DIFF_BITS    = COORD_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [TOL_BITS-1:0]          tol_type;
   typedef logic [CNT_BITS-1:0]          count_type;

   typedef struct packed {
      coord_type first_x;
      coord_type first_y;
      coord_type second_x;
      coord_type second_y;
   } seg_type;

   typedef struct packed {
      seg_type seg;
      logic    new_set;
   } item_type;

   typedef struct packed {
      seg_type               seg;
      logic                  kept;
      logic                  overflow;
      logic [TOTAL_BITS-1:0] kept_total;
   } result_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } scan_state_type;

   // The difference is formed one bit wider than the coordinates, so it never wraps.
   function automatic logic near_axis(coord_type a, coord_type b, tol_type tol);
      logic signed [DIFF_BITS-1:0] diff;
      logic [DIFF_BITS-1:0]        mag;
      diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      return mag <= {{(DIFF_BITS-TOL_BITS){1'b0}}, tol};
   endfunction

   function automatic logic near_point(coord_type ax, coord_type ay,
                                       coord_type bx, coord_type by, tol_type tol);
      return near_axis(ax, bx, tol) && near_axis(ay, by, tol);
   endfunction

   // Endpoints may pair up in the same order or swapped.
   function automatic logic near_segment(seg_type a, seg_type b, tol_type tol);
      logic same_order;
      logic swapped;
      same_order = near_point(a.first_x, a.first_y, b.first_x, b.first_y, tol) &&
                   near_point(a.second_x, a.second_y, b.second_x, b.second_y, tol);
      swapped    = near_point(a.first_x, a.first_y, b.second_x, b.second_y, tol) &&
                   near_point(a.second_x, a.second_y, b.first_x, b.first_y, tol);
      return same_order || swapped;
   endfunction

endpackage

// File: hdl/lsdf_front.sv
// Front end: two-entry request queue that takes segments with their new-set flags.
// Depends on lsdf_pkg.
`timescale 1ns / 1ps

module lsdf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  lsdf_pkg::item_type push_item,
   output logic               item_valid,
   output lsdf_pkg::item_type item,
   input  logic               item_take
);

   lsdf_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_push, do_take;

   assign full       = (fill_ff == 2'd2);
   assign item_valid = (fill_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_take ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_take) begin
         fill_in = fill_ff + 2'd1;
      end else if (!do_push && do_take) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/lsdf_scan.sv
// Back end: segment table memory and the engine that scans it for near matches.
// Depends on lsdf_pkg.
`timescale 1ns / 1ps

module lsdf_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  lsdf_pkg::tol_type    tolerance,
   input  logic                 item_valid,
   input  lsdf_pkg::item_type   item,
   output logic                 item_take,
   output logic                 rsp_push,
   output lsdf_pkg::result_type rsp_item,
   input  logic                 rsp_full
);

   lsdf_pkg::scan_state_type state_ff, state_in;
   lsdf_pkg::seg_type        cur_ff, cur_in;
   lsdf_pkg::count_type      count_ff, count_in;
   lsdf_pkg::count_type      idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic                     found_ff, found_in;
   lsdf_pkg::seg_type        rd_data_ff;
   lsdf_pkg::seg_type        mem [lsdf_pkg::MAX_SEGMENTS];

   logic issue;
   logic found_now;
   logic scan_over;
   logic has_room;
   logic wr_en;

   // A read issued in one cycle is compared in the next, when its data is registered.
   assign found_now = found_ff || (pend_ff && lsdf_pkg::near_segment(cur_ff, rd_data_ff,
                                                                    tolerance));
   assign issue     = (state_ff == lsdf_pkg::S_SCAN) && (idx_ff < count_ff) && !found_now;
   assign scan_over = found_now || ((idx_ff >= count_ff) && !pend_ff);
   assign has_room  = count_ff < lsdf_pkg::CNT_BITS'(lsdf_pkg::MAX_SEGMENTS);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsdf_pkg::S_IDLE: begin
            if (item_valid) begin
               state_in = lsdf_pkg::S_SCAN;
            end
         end
         lsdf_pkg::S_SCAN: begin
            if (scan_over) begin
               state_in = lsdf_pkg::S_DONE;
            end
         end
         lsdf_pkg::S_DONE: begin
            if (!rsp_full) begin
               state_in = lsdf_pkg::S_IDLE;
            end
         end
         default: state_in = lsdf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      item_take = 1'b0;
      rsp_push  = 1'b0;
      wr_en     = 1'b0;
      cur_in    = cur_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      found_in  = found_ff;
      unique case (state_ff)
         lsdf_pkg::S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               cur_in    = item.seg;
               idx_in    = '0;
               found_in  = 1'b0;
               if (item.new_set) begin
                  count_in = '0;
               end
            end
         end
         lsdf_pkg::S_SCAN: begin
            pend_in  = issue;
            found_in = found_now;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         lsdf_pkg::S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (!found_ff && has_room) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_item.seg        = cur_ff;
      rsp_item.kept       = !found_ff && has_room;
      rsp_item.overflow   = !found_ff && !has_room;
      rsp_item.kept_total = lsdf_pkg::TOTAL_BITS'((!found_ff && has_room) ?
                                                  count_ff + 1'b1 : count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsdf_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[lsdf_pkg::ADDR_BITS-1:0]] <= cur_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[lsdf_pkg::ADDR_BITS-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lsdf_pkg::CNT_BITS'(lsdf_pkg::MAX_SEGMENTS))
      else $error("segment count beyond table size");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == lsdf_pkg::S_SCAN)
      else $error("outstanding table read outside the scan");

   a_write_unmatched: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == lsdf_pkg::S_DONE) && !found_ff && rsp_push)
      else $error("table written for a matched segment");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> state_ff == lsdf_pkg::S_IDLE)
      else $error("engine did not return to idle after a result beat");

endmodule

// File: hdl/lsdf_rsp_queue.sv
// Result queue: two-entry buffer between the scan engine and the result ports.
// Depends on lsdf_pkg.
`timescale 1ns / 1ps

module lsdf_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lsdf_pkg::result_type push_item,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output lsdf_pkg::result_type head
);

   lsdf_pkg::result_type slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/line_segment_near_duplicate_filter.sv
// Channel   | Ports                          | Beat moves when
// ----------+--------------------------------+--------------------------
// request   | push, full, req_*              | push high and full low
// response  | pop, empty, rsp_*              | pop high and empty low
// csr       | csr_write_enable, csr_write_data | csr_write_enable high
//
// A segment passes through the idle, scan and done states of the scan engine. The scan reads
// one table entry per cycle from the table memory, over the stored segments counted after
// any new set has cleared the table, and stops at the first near match.
// Reset clears the segment count, the queues and the tolerance; the table needs no clearing.
// Two segments may wait in the request queue and two results in the response queue,
// so a stalled response side only holds the scan once both results are waiting.
`timescale 1ns / 1ps

module line_segment_near_duplicate_filter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   output logic                                     full,
   input  logic signed [lsdf_pkg::COORD_BITS-1:0]   req_first_x,
   input  logic signed [lsdf_pkg::COORD_BITS-1:0]   req_first_y,
   input  logic signed [lsdf_pkg::COORD_BITS-1:0]   req_second_x,
   input  logic signed [lsdf_pkg::COORD_BITS-1:0]   req_second_y,
   input  logic                                     req_new_set,
   output logic                                     empty,
   input  logic                                     pop,
   output logic signed [lsdf_pkg::COORD_BITS-1:0]   rsp_out_first_x,
   output logic signed [lsdf_pkg::COORD_BITS-1:0]   rsp_out_first_y,
   output logic signed [lsdf_pkg::COORD_BITS-1:0]   rsp_out_second_x,
   output logic signed [lsdf_pkg::COORD_BITS-1:0]   rsp_out_second_y,
   output logic                                     rsp_kept,
   output logic                                     rsp_overflow,
   output logic [lsdf_pkg::TOTAL_BITS-1:0]          rsp_kept_total,
   input  logic                                     csr_write_enable,
   input  logic [lsdf_pkg::TOL_BITS-1:0]            csr_write_data
);

   lsdf_pkg::tol_type    csr_match_tolerance_ff;
   lsdf_pkg::item_type   push_item;
   lsdf_pkg::item_type   item;
   logic                 item_valid;
   logic                 item_take;
   logic                 rsp_push;
   logic                 rsp_full;
   lsdf_pkg::result_type rsp_item;
   lsdf_pkg::result_type rsp_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_match_tolerance_ff <= '0;
      end else if (csr_write_enable) begin
         csr_match_tolerance_ff <= csr_write_data;
      end
   end

   always_comb begin
      push_item.seg.first_x  = req_first_x;
      push_item.seg.first_y  = req_first_y;
      push_item.seg.second_x = req_second_x;
      push_item.seg.second_y = req_second_y;
      push_item.new_set      = req_new_set;
   end

   lsdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .push_item  (push_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   lsdf_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .tolerance  (csr_match_tolerance_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item),
      .rsp_full   (rsp_full)
   );

   lsdf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .full      (rsp_full),
      .empty     (empty),
      .pop       (pop),
      .head      (rsp_head)
   );

   assign rsp_out_first_x  = rsp_head.seg.first_x;
   assign rsp_out_first_y  = rsp_head.seg.first_y;
   assign rsp_out_second_x = rsp_head.seg.second_x;
   assign rsp_out_second_y = rsp_head.seg.second_y;
   assign rsp_kept         = rsp_head.kept;
   assign rsp_overflow     = rsp_head.overflow;
   assign rsp_kept_total   = rsp_head.kept_total;

endmodule

// File: bench/line_segment_near_duplicate_filter_test.sv
// Self-checking bench for line_segment_near_duplicate_filter: directed and random segments.
// A scoreboard class keeps its own segment table and predicts every response beat.
// Depends on lsdf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module line_segment_near_duplicate_filter_test;

   localparam int CYCLE_LIMIT = 3000000;

   class duplicate_filter_scoreboard;
      lsdf_pkg::seg_type    segment_table [lsdf_pkg::MAX_SEGMENTS];
      int unsigned          stored;
      lsdf_pkg::tol_type    tolerance;
      lsdf_pkg::result_type awaited_results [$];
      int unsigned          failures;

      function new();
         stored    = 0;
         tolerance = '0;
         failures  = 0;
      endfunction

      function void set_tolerance(lsdf_pkg::tol_type value);
         tolerance = value;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Differences are taken in int, so they never wrap at the coordinate width.
      function bit axis_close(lsdf_pkg::coord_type a, lsdf_pkg::coord_type b);
         int gap;
         gap = int'(a) - int'(b);
         if (gap < 0) gap = -gap;
         return gap <= int'(tolerance);
      endfunction

      function bit point_close(lsdf_pkg::coord_type ax, lsdf_pkg::coord_type ay,
                               lsdf_pkg::coord_type bx, lsdf_pkg::coord_type by);
         return axis_close(ax, bx) && axis_close(ay, by);
      endfunction

      function void note_segment(lsdf_pkg::seg_type s, logic new_set);
         lsdf_pkg::result_type outcome;
         bit                   hit;
         lsdf_pkg::seg_type    e;
         if (new_set) stored = 0;
         hit = 0;
         for (int unsigned i = 0; i < stored && !hit; i++) begin
            e   = segment_table[i];
            hit = (point_close(s.first_x, s.first_y, e.first_x, e.first_y) &&
                   point_close(s.second_x, s.second_y, e.second_x, e.second_y)) ||
                  (point_close(s.first_x, s.first_y, e.second_x, e.second_y) &&
                   point_close(s.second_x, s.second_y, e.first_x, e.first_y));
         end
         outcome.seg      = s;
         outcome.kept     = 1'b0;
         outcome.overflow = 1'b0;
         if (!hit) begin
            if (stored < lsdf_pkg::MAX_SEGMENTS) begin
               segment_table[stored] = s;
               stored++;
               outcome.kept = 1'b1;
            end else begin
               outcome.overflow = 1'b1;
            end
         end
         outcome.kept_total = lsdf_pkg::TOTAL_BITS'(stored);
         awaited_results.insert(awaited_results.size(), outcome);
      endfunction

      function void compare_field(string field, int expected_value, int actual_value);
         if (expected_value != actual_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected_value, actual_value);
            failures++;
         end
      endfunction

      function void check_result(lsdf_pkg::result_type got);
         lsdf_pkg::result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: response beat with no segment waiting, expected none, actual %h",
                     $time, got);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("out_first_x", want.seg.first_x, got.seg.first_x);
         compare_field("out_first_y", want.seg.first_y, got.seg.first_y);
         compare_field("out_second_x", want.seg.second_x, got.seg.second_x);
         compare_field("out_second_y", want.seg.second_y, got.seg.second_y);
         compare_field("kept", want.kept, got.kept);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("kept_total", want.kept_total, got.kept_total);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            push;
   logic                            full;
   lsdf_pkg::coord_type             req_first_x;
   lsdf_pkg::coord_type             req_first_y;
   lsdf_pkg::coord_type             req_second_x;
   lsdf_pkg::coord_type             req_second_y;
   logic                            req_new_set;
   logic                            empty;
   logic                            pop;
   lsdf_pkg::coord_type             rsp_out_first_x;
   lsdf_pkg::coord_type             rsp_out_first_y;
   lsdf_pkg::coord_type             rsp_out_second_x;
   lsdf_pkg::coord_type             rsp_out_second_y;
   logic                            rsp_kept;
   logic                            rsp_overflow;
   logic [lsdf_pkg::TOTAL_BITS-1:0] rsp_kept_total;
   logic                            csr_write_enable;
   lsdf_pkg::tol_type               csr_write_data;

   duplicate_filter_scoreboard filter_sb;

   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int                cur_tol;
   int                set_left;
   int                set_pos;
   bit                fill_mode;
   bit                long_allowed;
   bit                next_long;
   lsdf_pkg::seg_type set_history [$];

   line_segment_near_duplicate_filter dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_first_x      (req_first_x),
      .req_first_y      (req_first_y),
      .req_second_x     (req_second_x),
      .req_second_y     (req_second_y),
      .req_new_set      (req_new_set),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_first_x  (rsp_out_first_x),
      .rsp_out_first_y  (rsp_out_first_y),
      .rsp_out_second_x (rsp_out_second_x),
      .rsp_out_second_y (rsp_out_second_y),
      .rsp_kept         (rsp_kept),
      .rsp_overflow     (rsp_overflow),
      .rsp_kept_total   (rsp_kept_total),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every handshake is observed here, before the block updates at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) filter_sb.set_tolerance(csr_write_data);
         if (push && !full) begin
            filter_sb.note_segment('{req_first_x, req_first_y, req_second_x, req_second_y},
                                   req_new_set);
         end
         if (pop && !empty) begin
            filter_sb.check_result('{'{rsp_out_first_x, rsp_out_first_y,
                                       rsp_out_second_x, rsp_out_second_y},
                                     rsp_kept, rsp_overflow, rsp_kept_total});
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         pop = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** line_segment_near_duplicate_filter: FAILED **");
      $finish;
   end

   function automatic lsdf_pkg::item_type seg_item(int fx, int fy, int sx, int sy, bit ns);
      lsdf_pkg::item_type it;
      it.seg.first_x  = lsdf_pkg::coord_type'(fx);
      it.seg.first_y  = lsdf_pkg::coord_type'(fy);
      it.seg.second_x = lsdf_pkg::coord_type'(sx);
      it.seg.second_y = lsdf_pkg::coord_type'(sy);
      it.new_set      = ns;
      return it;
   endfunction

   function automatic lsdf_pkg::coord_type pick_extreme();
      case ($urandom_range(3))
         0:       return lsdf_pkg::coord_type'(-32768);
         1:       return lsdf_pkg::coord_type'(32767);
         2:       return lsdf_pkg::coord_type'(0);
         default: return lsdf_pkg::coord_type'(-1);
      endcase
   endfunction

   // Moves a coordinate right onto or just past the tolerance edge, or anywhere up to just past it.
   function automatic lsdf_pkg::coord_type nudge(lsdf_pkg::coord_type c);
      int off;
      int v;
      case ($urandom_range(5))
         0:       off = -(cur_tol + 1);
         1:       off = -cur_tol;
         2:       off = 0;
         3:       off = cur_tol;
         4:       off = cur_tol + 1;
         default: off = int'($urandom_range(2 * cur_tol + 2)) - (cur_tol + 1);
      endcase
      v = int'(c) + off;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return lsdf_pkg::coord_type'(v);
   endfunction

   // Sets of segments, many of them near copies of earlier members, with some stray restarts.
   // A long set never restarts early, so it runs the table past full.
   function automatic lsdf_pkg::item_type next_random_item();
      lsdf_pkg::item_type it;
      lsdf_pkg::seg_type  base;
      int unsigned        pick;
      int unsigned        copy_pct;
      it.new_set = 1'b0;
      if (set_left == 0) begin
         it.new_set = 1'b1;
         fill_mode  = next_long || (long_allowed && $urandom_range(7) == 0);
         next_long  = 1'b0;
         set_left   = fill_mode ? $urandom_range(272, 290) : $urandom_range(1, 40);
         set_pos    = 0;
         set_history.delete();
      end else if (!fill_mode && $urandom_range(99) < 3) begin
         it.new_set = 1'b1;
         set_pos    = 0;
         set_history.delete();
      end
      set_left--;
      set_pos++;
      if (fill_mode) copy_pct = (set_pos > lsdf_pkg::MAX_SEGMENTS) ? 50 : 3;
      else copy_pct = 45;
      pick = $urandom_range(99);
      if (set_history.size() != 0 && pick < copy_pct) begin
         base = set_history[$urandom_range(set_history.size() - 1)];
         if ($urandom_range(1)) begin
            it.seg = '{nudge(base.second_x), nudge(base.second_y),
                       nudge(base.first_x), nudge(base.first_y)};
         end else begin
            it.seg = '{nudge(base.first_x), nudge(base.first_y),
                       nudge(base.second_x), nudge(base.second_y)};
         end
      end else if (pick < copy_pct + 8) begin
         it.seg = '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
      end else begin
         it.seg = '{lsdf_pkg::coord_type'($urandom), lsdf_pkg::coord_type'($urandom),
                    lsdf_pkg::coord_type'($urandom), lsdf_pkg::coord_type'($urandom)};
      end
      set_history.insert(set_history.size(), it.seg);
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat was taken.
   task automatic send_segment(input lsdf_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push         = 1'b1;
      req_first_x  = it.seg.first_x;
      req_first_y  = it.seg.first_y;
      req_second_x = it.seg.second_x;
      req_second_y = it.seg.second_y;
      req_new_set  = it.new_set;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   // The tolerance only changes once every response beat has come back.
   task automatic write_tolerance(input lsdf_pkg::tol_type value);
      push = 1'b0;
      while (filter_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      cur_tol          = int'(value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_random_block(input int items, input lsdf_pkg::tol_type tol,
                                   input bit allow_long, input bit first_long);
      write_tolerance(tol);
      set_left     = 0;
      long_allowed = allow_long;
      next_long    = first_long;
      repeat (items) send_segment(next_random_item());
   endtask

   initial begin
      filter_sb        = new();
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_first_x      = '0;
      req_first_y      = '0;
      req_second_x     = '0;
      req_second_y     = '0;
      req_new_set      = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 18;
      recv_idle_pct    = 48;
      cur_tol          = 0;
      set_left         = 0;
      set_pos          = 0;
      fill_mode        = 1'b0;
      long_allowed     = 1'b0;
      next_long        = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Exact matching: corner coordinates, repeats, swapped endpoints, off by one.
      write_tolerance(16'd0);
      send_segment(seg_item(-32768, -32768, 32767, 32767, 1'b1));
      send_segment(seg_item(-32768, -32768, 32767, 32767, 1'b0));
      send_segment(seg_item(32767, 32767, -32768, -32768, 1'b0));
      send_segment(seg_item(-32767, -32768, 32767, 32767, 1'b0));
      send_segment(seg_item(0, 0, 0, 0, 1'b0));
      send_segment(seg_item(-1, -1, -1, -1, 1'b0));
      send_segment(seg_item(0, 0, 0, 0, 1'b1));
      send_segment(seg_item(32767, -32768, -32768, 32767, 1'b0));

      // Tolerance of one: inside, just outside, and inside with swapped order.
      write_tolerance(16'd1);
      send_segment(seg_item(100, 100, 200, 200, 1'b1));
      send_segment(seg_item(101, 99, 199, 201, 1'b0));
      send_segment(seg_item(202, 200, 100, 100, 1'b0));
      send_segment(seg_item(201, 201, 99, 101, 1'b0));

      // Widest tolerance: opposite corners are still the same point.
      write_tolerance(16'hFFFF);
      send_segment(seg_item(-32768, -32768, -32768, -32768, 1'b1));
      send_segment(seg_item(32767, 32767, 32767, 32767, 1'b0));
      send_segment(seg_item(0, 0, 0, 0, 1'b0));

      // One below the widest: a full-range difference no longer matches.
      write_tolerance(16'hFFFE);
      send_segment(seg_item(-32768, 0, 0, 0, 1'b1));
      send_segment(seg_item(32767, 0, 0, 0, 1'b0));
      send_segment(seg_item(32766, 0, 0, 0, 1'b0));
      send_segment(seg_item(32766, 0, 0, 0, 1'b1));

      // The first block opens with a set long enough to fill the table.
      run_random_block(300, 16'd0, 1'b1, 1'b1);
      run_random_block(170, lsdf_pkg::tol_type'($urandom_range(1, 8)), 1'b1, 1'b0);

      send_idle_pct = 48;
      recv_idle_pct = 18;
      run_random_block(170, 16'hFFFF, 1'b0, 1'b0);
      run_random_block(170, lsdf_pkg::tol_type'($urandom_range(9, 1000)), 1'b0, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_block(170, 16'd1, 1'b1, 1'b0);
      run_random_block(170, lsdf_pkg::tol_type'($urandom_range(0, 65535)), 1'b0, 1'b0);

      push = 1'b0;
      while (filter_sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (filter_sb.failures == 0) begin
         $display("** line_segment_near_duplicate_filter: PASSED **");
      end else begin
         $display("** line_segment_near_duplicate_filter: FAILED **");
      end
      $finish;
   end

endmodule
